// ----- hdl/xsg_pkg.sv -----
// ----------------------------------------------------------------------------
// xsg_pkg
// Shared types, constants and helpers for the xoroshiro128** generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xsg_pkg;

    localparam int WORD_W  = 64;
    localparam int MODE_W  = 2;
    localparam int FOLD_W  = 32;
    localparam int NNEG_W  = 63;
    localparam int FRAC_W  = 52;
    localparam int SHIFT_W = 6;
    localparam int OP_W    = 2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_SEED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;

    // command codes passed from front to back
    localparam logic [OP_W-1:0] OP_SEED  = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;
    localparam logic [OP_W-1:0] OP_LOW   = 2'd3;

    localparam logic [WORD_W-1:0] GOLDEN_STEP     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] GOLDEN_STEP_TWO = 64'h3C6E_F372_FE94_F82A;
    localparam logic [WORD_W-1:0] MIX_MUL_ONE     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_TWO     = 64'h94D0_49BB_1331_11EB;

    // splitmix64 outputs of seed zero
    localparam logic [WORD_W-1:0] SEED_ZERO_A = 64'hE220_A839_7B1D_CDAF;
    localparam logic [WORD_W-1:0] SEED_ZERO_B = 64'h6E78_9E6A_A1B9_65F4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WORD_W-1:0]  data;   // seed or low bound
        logic [WORD_W-1:0]  span;
        logic [SHIFT_W-1:0] shift;
    } xsg_cmd_t;

    // leading zero count, byte-wise then across bytes
    function automatic logic [SHIFT_W-1:0] lead_zeros(input logic [WORD_W-1:0] v);
        logic [7:0] nz;
        logic [2:0] bz [8];
        logic [2:0] hi_pos;
        logic [2:0] sel;
        for (int i = 0; i < 8; i++)
        begin
            nz[i]  = |v[8*i +: 8];
            hi_pos = '0;
            for (int j = 0; j < 8; j++)
            begin
                if (v[8*i+j])
                begin
                    hi_pos = 3'(j);
                end
            end
            bz[i] = 3'd7 - hi_pos;
        end
        sel = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (nz[i])
            begin
                sel = 3'(i);
            end
        end
        return {3'd7 - sel, bz[sel]};
    endfunction

endpackage

// ----- hdl/xsg_if.sv -----
// ----------------------------------------------------------------------------
// xsg_if
// Request and result channels of the generator, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xsg_req_if import xsg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] seed_value;
    logic [WORD_W-1:0] range_low;
    logic [WORD_W-1:0] range_high;

    modport source (output valid, mode, seed_value, range_low, range_high, input ready);
    modport sink (input valid, mode, seed_value, range_low, range_high, output ready);
endinterface

interface xsg_rsp_if import xsg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic [FOLD_W-1:0] fold32;
    logic [NNEG_W-1:0] nonneg63;
    logic              coin;
    logic [FRAC_W-1:0] fraction52;

    modport source (output valid, word, fold32, nonneg63, coin, fraction52, input ready);
    modport sink (input valid, word, fold32, nonneg63, coin, fraction52, output ready);
endinterface

// ----- hdl/xsg_front.sv -----
// ----------------------------------------------------------------------------
// xsg_front
// Takes request items, decodes mode, computes range span and shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsg_front import xsg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    xsg_req_if.sink  req,
    output logic     push_valid,
    input  logic     push_ready,
    output xsg_cmd_t push_data
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [OP_W-1:0]   s1_op_reg;
    logic [OP_W-1:0]   s1_op_next;
    logic [WORD_W-1:0] s1_data_reg;
    logic [WORD_W-1:0] s1_data_next;
    logic [WORD_W-1:0] s1_span_reg;
    logic [WORD_W-1:0] s1_span_next;

    logic              accept;
    logic              leave;
    logic              keep;
    logic [WORD_W:0]   diff;
    logic              empty;

    assign leave     = s1_valid_reg && push_ready;
    assign req.ready = !s1_valid_reg || push_ready;
    assign accept    = req.valid && req.ready;

    assign diff  = {1'b0, req.range_high} - {1'b0, req.range_low};
    assign empty = diff[WORD_W] || (diff[WORD_W-1:0] == '0);

    always_comb
    begin
        keep       = 1'b1;
        s1_op_next = OP_DRAW;
        unique case (req.mode)
            MODE_SEED:  s1_op_next = OP_SEED;
            MODE_DRAW:  s1_op_next = OP_DRAW;
            MODE_RANGE: s1_op_next = empty ? OP_LOW : OP_RANGE;
            default:    keep = 1'b0;   // unused mode is dropped
        endcase
        s1_data_next = (req.mode == MODE_SEED) ? req.seed_value : req.range_low;
        s1_span_next = diff[WORD_W-1:0];

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = keep;
        end
        else if (leave)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= s1_op_next;
            s1_data_reg <= s1_data_next;
            s1_span_reg <= s1_span_next;
        end
    end

    assign push_valid      = s1_valid_reg;
    assign push_data.op    = s1_op_reg;
    assign push_data.data  = s1_data_reg;
    assign push_data.span  = s1_span_reg;
    assign push_data.shift = lead_zeros(s1_span_reg);

endmodule

// ----- hdl/xsg_queue.sv -----
// ----------------------------------------------------------------------------
// xsg_queue
// Small command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsg_queue import xsg_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  xsg_cmd_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output xsg_cmd_t pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    xsg_cmd_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/xsg_mix.sv -----
// ----------------------------------------------------------------------------
// xsg_mix
// splitmix64 finalizer on one shared 32x32 multiplier, eight steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsg_mix import xsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] x,
    output logic              done,
    output logic [WORD_W-1:0] z
);

    logic              busy_reg;
    logic              phase_reg;
    logic [1:0]        step_reg;
    logic              done_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] prod_reg;

    logic [WORD_W-1:0] mul_const;
    logic [31:0]       a_op;
    logic [31:0]       b_op;
    logic [WORD_W-1:0] pp;

    assign mul_const = phase_reg ? MIX_MUL_TWO : MIX_MUL_ONE;

    // low 64 bits of x * C from three partial products
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                a_op = x_reg[31:0];
                b_op = mul_const[31:0];
            end
            2'd1:
            begin
                a_op = x_reg[63:32];
                b_op = mul_const[31:0];
            end
            2'd2:
            begin
                a_op = x_reg[31:0];
                b_op = mul_const[63:32];
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign pp = 64'(a_op) * 64'(b_op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == 2'd3) && phase_reg;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                step_reg  <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    if (phase_reg)
                    begin
                        busy_reg <= 1'b0;
                    end
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x ^ (x >> 30);
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                2'd0:
                begin
                    prod_reg <= pp;
                end
                2'd1, 2'd2:
                begin
                    prod_reg[63:32] <= prod_reg[63:32] + pp[31:0];
                end
                default:
                begin
                    if (!phase_reg)
                    begin
                        x_reg <= prod_reg ^ (prod_reg >> 27);
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign z    = prod_reg ^ (prod_reg >> 31);

endmodule

// ----- hdl/xsg_back.sv -----
// ----------------------------------------------------------------------------
// xsg_back
// Generator state, reseed sequencing, draws with rejection, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsg_back import xsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  xsg_cmd_t  pop_data,
    xsg_rsp_if.source rsp
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEED_A = 3'd1;
    localparam logic [2:0] ST_SEED_B = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [WORD_W-1:0]  word_a_reg;
    logic [WORD_W-1:0]  word_a_next;
    logic [WORD_W-1:0]  word_b_reg;
    logic [WORD_W-1:0]  word_b_next;
    logic [OP_W-1:0]    cmd_op_reg;
    logic [OP_W-1:0]    cmd_op_next;
    logic [WORD_W-1:0]  cmd_data_reg;
    logic [WORD_W-1:0]  cmd_data_next;
    logic [WORD_W-1:0]  cmd_span_reg;
    logic [WORD_W-1:0]  cmd_span_next;
    logic [SHIFT_W-1:0] cmd_shift_reg;
    logic [SHIFT_W-1:0] cmd_shift_next;
    logic [WORD_W-1:0]  p_reg;
    logic [WORD_W-1:0]  p_next;
    logic [WORD_W-1:0]  val_reg;
    logic [WORD_W-1:0]  val_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [WORD_W-1:0]  out_word_reg;
    logic [WORD_W-1:0]  out_word_next;
    logic [FOLD_W-1:0]  out_fold_reg;
    logic [FOLD_W-1:0]  out_fold_next;
    logic [NNEG_W-1:0]  out_nneg_reg;
    logic [NNEG_W-1:0]  out_nneg_next;
    logic               out_coin_reg;
    logic               out_coin_next;
    logic [FRAC_W-1:0]  out_frac_reg;
    logic [FRAC_W-1:0]  out_frac_next;

    logic               mix_start;
    logic [WORD_W-1:0]  mix_x;
    logic               mix_done;
    logic [WORD_W-1:0]  mix_z;

    logic               slot_free;
    logic [WORD_W-1:0]  a5;
    logic [WORD_W-1:0]  t;
    logic [WORD_W-1:0]  raw;
    logic [WORD_W-1:0]  shifted;

    xsg_mix u_mix
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .x     (mix_x),
        .done  (mix_done),
        .z     (mix_z)
    );

    assign slot_free = !out_valid_reg || rsp.ready;
    assign a5        = word_a_reg + (word_a_reg << 2);
    assign t         = word_a_reg ^ word_b_reg;
    assign raw       = p_reg + (p_reg << 3);
    assign shifted   = raw >> cmd_shift_reg;

    always_comb
    begin
        state_next     = state_reg;
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;
        cmd_op_next    = cmd_op_reg;
        cmd_data_next  = cmd_data_reg;
        cmd_span_next  = cmd_span_reg;
        cmd_shift_next = cmd_shift_reg;
        p_next         = p_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_word_next  = out_word_reg;
        out_fold_next  = out_fold_reg;
        out_nneg_next  = out_nneg_reg;
        out_coin_next  = out_coin_reg;
        out_frac_next  = out_frac_reg;
        pop_ready      = 1'b0;
        mix_start      = 1'b0;
        mix_x          = cmd_data_reg + GOLDEN_STEP_TWO;

        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_op_next    = pop_data.op;
                    cmd_data_next  = pop_data.data;
                    cmd_span_next  = pop_data.span;
                    cmd_shift_next = pop_data.shift;
                    unique case (pop_data.op)
                        OP_SEED:
                        begin
                            mix_start  = 1'b1;
                            mix_x      = pop_data.data + GOLDEN_STEP;
                            state_next = ST_SEED_A;
                        end
                        OP_DRAW, OP_RANGE:
                        begin
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            // empty range: low bound, state untouched
                            val_next   = '0;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SEED_A:
            begin
                if (mix_done)
                begin
                    word_a_next = mix_z;
                    mix_start   = 1'b1;
                    state_next  = ST_SEED_B;
                end
            end
            ST_SEED_B:
            begin
                if (mix_done)
                begin
                    word_b_next = mix_z;
                    state_next  = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                p_next      = {a5[56:0], a5[63:57]};
                word_a_next = {word_a_reg[39:0], word_a_reg[63:40]} ^ t ^ (t << 16);
                word_b_next = {t[26:0], t[63:27]};
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (cmd_op_reg == OP_DRAW)
                begin
                    val_next   = raw;
                    state_next = ST_EMIT;
                end
                else if (shifted <= cmd_span_reg)
                begin
                    val_next   = shifted;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_STEP;   // rejected, draw again
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_op_reg == OP_DRAW)
                    begin
                        out_word_next = val_reg;
                        out_fold_next = val_reg[63:32] ^ val_reg[31:0];
                        out_nneg_next = val_reg[62:0];
                        out_coin_next = val_reg[0];
                        out_frac_next = val_reg[51:0];
                    end
                    else
                    begin
                        out_word_next = cmd_data_reg + val_reg;
                        out_fold_next = '0;
                        out_nneg_next = '0;
                        out_coin_next = 1'b0;
                        out_frac_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_a_reg    <= SEED_ZERO_A;
            word_b_reg    <= SEED_ZERO_B;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_a_reg    <= word_a_next;
            word_b_reg    <= word_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_op_reg    <= cmd_op_next;
        cmd_data_reg  <= cmd_data_next;
        cmd_span_reg  <= cmd_span_next;
        cmd_shift_reg <= cmd_shift_next;
        p_reg         <= p_next;
        val_reg       <= val_next;
        out_word_reg  <= out_word_next;
        out_fold_reg  <= out_fold_next;
        out_nneg_reg  <= out_nneg_next;
        out_coin_reg  <= out_coin_next;
        out_frac_reg  <= out_frac_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.word       = out_word_reg;
    assign rsp.fold32     = out_fold_reg;
    assign rsp.nonneg63   = out_nneg_reg;
    assign rsp.coin       = out_coin_reg;
    assign rsp.fraction52 = out_frac_reg;

endmodule

// ----- hdl/xoroshiro128ss_generator_top.sv -----
// ----------------------------------------------------------------------------
// xoroshiro128ss_generator_top
// Flow: an item passes the front register and the queue; for a draw the back
// unit runs IDLE, STEP, CHECK, EMIT, waiting in EMIT while the output is held,
// and repeats STEP, CHECK per rejected range value; it takes commands only in
// IDLE. A reseed runs two splitmix passes on one shared 32x32 multiplier.
// Reset: queue and output empty, state holds the splitmix outputs of seed 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xoroshiro128ss_generator_top import xsg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    xsg_req_if.sink   req,
    xsg_rsp_if.source rsp
);

    logic     push_valid;
    logic     push_ready;
    xsg_cmd_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    xsg_cmd_t pop_data;

    xsg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    xsg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    xsg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

// ----- dv/xsg_checker.sv -----
// ----------------------------------------------------------------------------
// xsg_checker
// Watches the request and result channels of the xoroshiro128** generator,
// keeps its own copy of the 128-bit state, works out the result of every
// accepted draw and compares each delivered result against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsg_checker import xsg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xsg_req_if   req,
    xsg_rsp_if   rsp,
    output int   fail_count,
    output int   draws_owed
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [FOLD_W-1:0] fold32;
        logic [NNEG_W-1:0] nonneg63;
        logic              coin;
        logic [FRAC_W-1:0] fraction52;
    } draw_t;

    draw_t             owed_q[$];
    logic [WORD_W-1:0] gen_a;
    logic [WORD_W-1:0] gen_b;

    // splitmix64 output stage, applied to the already advanced accumulator
    function automatic logic [WORD_W-1:0] mix64(input logic [WORD_W-1:0] z);
        logic [WORD_W-1:0] m;
        m = (z ^ (z >> 30)) * MIX_MUL_ONE;
        m = (m ^ (m >> 27)) * MIX_MUL_TWO;
        return m ^ (m >> 31);
    endfunction

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x, input int k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

    function automatic int msb_index(input logic [WORD_W-1:0] v);
        int p;
        p = 0;
        while (v > 64'd1)
        begin
            v = v >> 1;
            p++;
        end
        return p;
    endfunction

    task automatic load_seed(input logic [WORD_W-1:0] seed);
        gen_a = mix64(seed + GOLDEN_STEP);
        gen_b = mix64(seed + GOLDEN_STEP + GOLDEN_STEP);
    endtask

    // one xoroshiro128** step on the local state, returns the raw output
    task automatic gen_next(output logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] t;
        t     = gen_a ^ gen_b;
        raw   = rotl64(gen_a * 64'd5, 7) * 64'd9;
        gen_a = rotl64(gen_a, 24) ^ t ^ (t << 16);
        gen_b = rotl64(t, 37);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        draw_t             d;
        draw_t             got;
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] pick;
        int                sh;
        if (!rst_n)
        begin
            load_seed('0);
            owed_q.delete();
            fail_count = 0;
            draws_owed = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                d = '0;
                case (req.mode)
                    MODE_SEED:
                    begin
                        load_seed(req.seed_value);
                    end
                    MODE_DRAW:
                    begin
                        gen_next(raw);
                        d.word       = raw;
                        d.fold32     = raw[63:32] ^ raw[31:0];
                        d.nonneg63   = raw[62:0];
                        d.coin       = raw[0];
                        d.fraction52 = raw[51:0];
                        owed_q.push_back(d);
                    end
                    MODE_RANGE:
                    begin
                        pick = '0;
                        // empty range leaves the state alone
                        if (req.range_high > req.range_low)
                        begin
                            span = req.range_high - req.range_low;
                            sh   = 63 - msb_index(span);
                            do
                            begin
                                gen_next(raw);
                                pick = raw >> sh;
                            end
                            while (pick > span);
                        end
                        d.word = req.range_low + pick;
                        owed_q.push_back(d);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                got.word       = rsp.word;
                got.fold32     = rsp.fold32;
                got.nonneg63   = rsp.nonneg63;
                got.coin       = rsp.coin;
                got.fraction52 = rsp.fraction52;
                if (owed_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: result with none owed: word %h", $time, got.word);
                    end
                    fail_count++;
                end
                else
                begin
                    d = owed_q.pop_front();
                    if (got !== d)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  word       exp %h got %h", d.word, got.word);
                            $display("  fold32     exp %h got %h", d.fold32, got.fold32);
                            $display("  nonneg63   exp %h got %h", d.nonneg63, got.nonneg63);
                            $display("  coin       exp %b got %b", d.coin, got.coin);
                            $display("  fraction52 exp %h got %h", d.fraction52, got.fraction52);
                        end
                        fail_count++;
                    end
                end
            end
            draws_owed = owed_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the xoroshiro128** generator: a directed set of range edges,
// reseeds and ignored codes, then random reseeds, draws and range draws with
// bursts of idling on both channels. Checking is done by xsg_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import xsg_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                NUM_ITEMS   = 1200;
    localparam int                QUIET_TAIL  = 200;
    localparam int                CYCLE_LIMIT = 500000;
    localparam logic [WORD_W-1:0] ALL_ONES    = '1;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   draws_owed;
    int   cycle_count = 0;
    int   idle_pct = 0;
    int   stall_left = 0;

    xsg_req_if req_ch ();
    xsg_rsp_if rsp_ch ();

    xoroshiro128ss_generator_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    xsg_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .draws_owed (draws_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 3)
        begin
            stall_left   <= $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] seed,
                            input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        int gap;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.seed_value <= seed;
        req_ch.range_low  <= lo;
        req_ch.range_high <= hi;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic pick_range(output logic [WORD_W-1:0] lo, output logic [WORD_W-1:0] hi);
        case ($urandom_range(0, 5))
            0:
            begin
                lo = rand64();
                hi = lo + 64'($urandom_range(0, 20));
            end
            1:
            begin
                lo = rand64() >> $urandom_range(0, 63);
                hi = lo + (rand64() >> $urandom_range(0, 63));
            end
            2:
            begin
                lo = rand64();
                hi = rand64();
            end
            3:
            begin
                lo = '0;
                hi = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            end
            4:
            begin
                lo = ($urandom_range(0, 2) == 0) ? '0 :
                     (($urandom_range(0, 1) != 0) ? ALL_ONES : rand64());
                hi = ($urandom_range(0, 2) == 0) ? '0 :
                     (($urandom_range(0, 1) != 0) ? ALL_ONES : rand64());
            end
            default:
            begin
                lo = 64'($urandom_range(0, 1000));
                hi = lo + (rand64() >> $urandom_range(0, 63));
            end
        endcase
    endtask

    initial
    begin : stimulus
        logic [MODE_W-1:0] m;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        int                n;
        int                r;
        int                blk;
        int                last_blk;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= MODE_SEED;
        req_ch.seed_value <= '0;
        req_ch.range_low  <= '0;
        req_ch.range_high <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: state right after reset, range edges, ignored code, reseeds
        push_req(MODE_DRAW, '0, '0, '0);
        push_req(MODE_DRAW, '0, '0, '0);
        push_req(MODE_RANGE, '0, '0, ALL_ONES);                  // full span
        push_req(MODE_RANGE, '0, 64'd7, 64'd7);                  // empty
        push_req(MODE_RANGE, '0, ALL_ONES, '0);                  // inverted
        push_req(MODE_RANGE, '0, ALL_ONES, ALL_ONES);
        push_req(MODE_RANGE, '0, '0, 64'd1);
        push_req(MODE_RANGE, '0, ALL_ONES - 1, ALL_ONES);
        push_req(MODE_RANGE, '0, '0, 64'h8000_0000_0000_0000);
        push_req(MODE_RANGE, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        push_req(MODE_RANGE, '0, 64'd100, 64'd103);
        push_req(MODE_RANGE, '0, 64'h1_0000_0000, 64'h1_0000_0004);
        push_req(MODE_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        push_req(MODE_DRAW, '0, '0, '0);                         // state kept over mode 3
        push_req(MODE_SEED, '0, '0, '0);
        push_req(MODE_DRAW, '0, '0, '0);
        push_req(MODE_SEED, ALL_ONES, '0, '0);
        push_req(MODE_DRAW, '0, '0, '0);
        push_req(MODE_RANGE, '0, ALL_ONES - 5, ALL_ONES);
        push_req(MODE_SEED, rand64(), '0, '0);
        push_req(MODE_DRAW, '0, '0, '0);
        push_req(MODE_UNUSED, '0, '0, '0);
        push_req(MODE_RANGE, '0, '0, '0);
        push_req(MODE_DRAW, '0, '0, '0);

        n        = 0;
        last_blk = -1;
        while (n < NUM_ITEMS)
        begin
            blk = n / 100;
            if (n >= NUM_ITEMS - QUIET_TAIL)
            begin
                idle_pct = 0;
            end
            else if (blk != last_blk)
            begin
                last_blk = blk;
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 50;
                endcase
            end
            seed = rand64();
            lo   = rand64();
            hi   = rand64();
            r    = $urandom_range(0, 99);
            if (r < 6)
            begin
                m = MODE_SEED;
                case ($urandom_range(0, 7))
                    0:       seed = '0;
                    1:       seed = ALL_ONES;
                    2:       seed = 64'($urandom_range(0, 255));
                    default: seed = rand64();
                endcase
            end
            else if (r < 50)
            begin
                m = MODE_DRAW;
            end
            else if (r < 96)
            begin
                m = MODE_RANGE;
                pick_range(lo, hi);
            end
            else
            begin
                m = MODE_UNUSED;
            end
            push_req(m, seed, lo, hi);
            if (m != MODE_UNUSED)
            begin
                n++;
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (draws_owed != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
